### hdl/dqpd_pkg.sv
// shared types and constants of the dual quadrature pd motor control unit
`timescale 1ns / 1ps

package dqpd_pkg;

   // fixed field widths
   localparam int GAIN_W   = 24;
   localparam int TARGET_W = 16;
   localparam int DUTY_W   = 11;
   localparam int CSR_IDX_W = 2;

   // full power in the fixed point of the drive sum (2^-16 units)
   localparam int FULL_SHIFT = 16;
   localparam int MAG_W      = FULL_SHIFT + 1;
   localparam logic [MAG_W-1:0] FULL_POWER = MAG_W'(1) << FULL_SHIFT;

   // request opcodes
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D = 2'd1;

   // drive of one motor
   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              dir;
   } motor_drive_type;

endpackage

### hdl/dual_quadrature_pd_motor_control_unit.sv
// top level of the dual quadrature pd motor control unit
`timescale 1ns / 1ps

// two-motor position regulator with a fixed-point pd law
//
// request channel (req_*): one transaction per cycle, valid/stall handshake.
//   opcode edge: motor_sel picks a motor, its position count steps down when
//   the two channel levels match and up otherwise; no response is produced.
//   opcode tick: both targets; for each motor
//   sum = gain_p*(target-count) + gain_d*(prev-count), then prev takes count.
// response channel (rsp_*): one transaction per tick with duty and direction
//   of both motors; duty = |sum| >> 6 at 1024 full scale, saturated at full
//   power, forced to zero below 1% of full scale; dir is 1 for a positive sum.
// csr channel: csr_index 0 writes gain_p, 1 writes gain_d, others ignored;
//   csr_ready is always high; write only while the unit is idle.
// tick path: an accepted tick passes the snapshot, product and drive registers
//   in that order before it shows on rsp_valid.
// throughput: one transaction per cycle while req_stall is low; the three-stage
//   tick pipeline moves independently per stage, so bubbles fill while
//   rsp_stall is high and req_stall rises only once every stage holds a tick.
// reset (synchronous): counts, previous counts, gains and all valids clear.

module dual_quadrature_pd_motor_control_unit
   import dqpd_pkg::*;
#(
   parameter int COUNT_BITS = 16,
   parameter int DUTY_FULL  = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic                        req_motor_sel,
   input  logic                        req_level_c1,
   input  logic                        req_level_c2,
   input  logic signed [TARGET_W-1:0]  req_target_a,
   input  logic signed [TARGET_W-1:0]  req_target_b,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [DUTY_W-1:0]           rsp_duty_a,
   output logic                        rsp_dir_a,
   output logic [DUTY_W-1:0]           rsp_duty_b,
   output logic                        rsp_dir_b,
   // csr write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [GAIN_W-1:0]           csr_data
);

   // difference width covers target and count as signed values plus one
   localparam int DIFF_W = ((COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W) + 1;
   localparam int PROD_W = DIFF_W + GAIN_W;
   localparam int SUM_W  = PROD_W + 1;
   // duty scaling: saturated magnitude times full-scale duty, drop 16 bits
   localparam int DF_W   = $clog2(DUTY_FULL + 1);
   localparam int SCL_W  = MAG_W + DF_W;
   localparam logic [SCL_W-1:0] DUTY_FULL_C = SCL_W'(DUTY_FULL);
   localparam logic [SCL_W-1:0] MIN_DUTY    = SCL_W'(DUTY_FULL / 100);

   // configuration
   logic [GAIN_W-1:0] gain_p_ff, gain_p_in;
   logic [GAIN_W-1:0] gain_d_ff, gain_d_in;

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_adv;
   logic s2_adv;
   logic s1_adv;
   logic req_accept;
   logic edge_accept;
   logic tick_accept;

   motor_drive_type drive [2];

   assign csr_ready = 1'b1;

   // gains
   always_comb begin
      gain_p_in = gain_p_ff;
      gain_d_in = gain_d_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == REG_GAIN_P) begin
            gain_p_in = csr_data;
         end
         if (csr_index == REG_GAIN_D) begin
            gain_d_in = csr_data;
         end
      end
   end

   // each stage loads when it is empty or its content moves on
   assign out_adv     = !out_valid_ff || !rsp_stall;
   assign s2_adv      = !s2_valid_ff || out_adv;
   assign s1_adv      = !s1_valid_ff || s2_adv;
   assign req_stall   = !s1_adv;
   assign req_accept  = req_valid && !req_stall;
   assign edge_accept = req_accept && (req_opcode == OP_EDGE);
   assign tick_accept = req_accept && (req_opcode == OP_TICK);

   assign s1_valid_in  = s1_adv ? tick_accept : s1_valid_ff;
   assign s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_adv ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_d_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         gain_p_ff    <= gain_p_in;
         gain_d_ff    <= gain_d_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // per-motor datapath
   for (genvar m = 0; m < 2; m++) begin : g_motor
      logic [COUNT_BITS-1:0]      count_ff, count_in;
      logic [COUNT_BITS-1:0]      prev_ff, prev_in;
      logic signed [TARGET_W-1:0] tgt;
      // stage 1: snapshot of target, count and previous count
      logic [TARGET_W-1:0]        s1_tgt_ff;
      logic [COUNT_BITS-1:0]      s1_cnt_ff;
      logic [COUNT_BITS-1:0]      s1_prv_ff;
      // stage 2: the two products
      logic [DIFF_W-1:0]          diff_p;
      logic [DIFF_W-1:0]          diff_d;
      logic [PROD_W-1:0]          prod_p_in, prod_p_ff;
      logic [PROD_W-1:0]          prod_d_in, prod_d_ff;
      // output stage: drive
      logic [SUM_W-1:0]           sum;
      logic                       neg;
      logic [SUM_W-1:0]           mag;
      logic [MAG_W-1:0]           mag_sat;
      logic [SCL_W-1:0]           scaled;
      logic [SCL_W-1:0]           duty_raw;
      motor_drive_type            drive_in, drive_ff;

      assign tgt = (m == 0) ? req_target_a : req_target_b;

      // count update on edge events, prev takes count on ticks
      always_comb begin
         count_in = count_ff;
         prev_in  = prev_ff;
         if (edge_accept && (req_motor_sel == 1'(m))) begin
            if (req_level_c1 == req_level_c2) begin
               count_in = count_ff - COUNT_BITS'(1);
            end else begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
         if (tick_accept) begin
            prev_in = count_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            count_ff <= '0;
            prev_ff  <= '0;
         end else begin
            count_ff <= count_in;
            prev_ff  <= prev_in;
         end
      end

      always_ff @(posedge clock) begin
         if (s1_adv) begin
            s1_tgt_ff <= tgt;
            s1_cnt_ff <= count_ff;
            s1_prv_ff <= prev_ff;
         end
      end

      // signed differences, then signed products sized to hold the full result
      assign diff_p = {{(DIFF_W-TARGET_W){s1_tgt_ff[TARGET_W-1]}}, s1_tgt_ff}
                    - {{(DIFF_W-COUNT_BITS){s1_cnt_ff[COUNT_BITS-1]}}, s1_cnt_ff};
      assign diff_d = {{(DIFF_W-COUNT_BITS){s1_prv_ff[COUNT_BITS-1]}}, s1_prv_ff}
                    - {{(DIFF_W-COUNT_BITS){s1_cnt_ff[COUNT_BITS-1]}}, s1_cnt_ff};
      assign prod_p_in = $signed(diff_p) * $signed(gain_p_ff);
      assign prod_d_in = $signed(diff_d) * $signed(gain_d_ff);

      always_ff @(posedge clock) begin
         if (s2_adv) begin
            prod_p_ff <= prod_p_in;
            prod_d_ff <= prod_d_in;
         end
      end

      // sum, magnitude, saturation and duty scaling
      assign sum     = {prod_p_ff[PROD_W-1], prod_p_ff} + {prod_d_ff[PROD_W-1], prod_d_ff};
      assign neg     = sum[SUM_W-1];
      assign mag     = neg ? (SUM_W'(0) - sum) : sum;
      assign mag_sat = (mag > SUM_W'(FULL_POWER)) ? FULL_POWER : mag[MAG_W-1:0];
      assign scaled  = SCL_W'(mag_sat) * DUTY_FULL_C;
      assign duty_raw = scaled >> FULL_SHIFT;

      always_comb begin
         drive_in.duty = (duty_raw < MIN_DUTY) ? '0 : duty_raw[DUTY_W-1:0];
         drive_in.dir  = !neg && (sum != '0);
      end

      always_ff @(posedge clock) begin
         if (out_adv) begin
            drive_ff <= drive_in;
         end
      end

      assign drive[m] = drive_ff;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_duty_a = drive[0].duty;
   assign rsp_dir_a  = drive[0].dir;
   assign rsp_duty_b = drive[1].duty;
   assign rsp_dir_b  = drive[1].dir;

endmodule
